// ----- sv/u2a_pkg.sv -----
// shared types, constants and helpers for the unsigned to ascii converter
`default_nettype none
package u2a_pkg;

   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 7;
   localparam int DIGIT_W     = 4;
   localparam int STACK_DEPTH = 10;
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int PROD_W      = 2 * VALUE_W;
   localparam int RECIP_SHIFT = 35;
   localparam int QUO_W       = PROD_W - RECIP_SHIFT;

   // ceil(2^35 / 10), exact quotient for every 32-bit dividend
   localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
   localparam logic [CHAR_W-1:0] CHAR_A_BIAS = 7'd87;

   typedef struct packed {
      logic load;
      logic mul;
      logic step;
      logic emit;
   } u2a_cmd_type;

   typedef struct packed {
      logic hex;
      logic quo_zero;
      logic last_pop;
   } u2a_sts_type;

   function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] ext;
      ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      if (d < 4'd10) begin
         digit_glyph = CHAR_ZERO + ext;
      end else begin
         digit_glyph = CHAR_A_BIAS + ext;
      end
   endfunction

endpackage
`default_nettype wire

// ----- sv/u2a_dp.sv -----
// datapath: working value, reciprocal multiplier, digit stack and output register
`default_nettype none
module u2a_dp (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire u2a_pkg::u2a_cmd_type         cmd,
   output u2a_pkg::u2a_sts_type              sts,
   input  wire logic [u2a_pkg::VALUE_W-1:0]  req_value,
   input  wire logic                         req_hex_mode,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [u2a_pkg::CHAR_W-1:0]        rsp_ascii_char,
   output logic                              rsp_last_char
);
   import u2a_pkg::*;

   logic [VALUE_W-1:0] work_ff, work_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic               hex_ff, hex_in;
   logic [DIGIT_W-1:0] stack_ff [STACK_DEPTH];
   logic [DIGIT_W-1:0] stack_in [STACK_DEPTH];
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [VALUE_W-1:0] dec_quo, dec_rem, quo;
   logic [DIGIT_W-1:0] digit;
   logic               space, pop;

   assign prod_in = PROD_W'(work_ff) * PROD_W'(RECIP_TEN);

   // remainder = work - 10 * quotient, via shift and add
   assign dec_quo = {{(VALUE_W-QUO_W){1'b0}}, prod_ff[PROD_W-1:RECIP_SHIFT]};
   assign dec_rem = work_ff - {dec_quo[VALUE_W-4:0], 3'b000} - {dec_quo[VALUE_W-2:0], 1'b0};

   always_comb begin
      if (hex_ff) begin
         quo   = {4'b0000, work_ff[VALUE_W-1:4]};
         digit = work_ff[DIGIT_W-1:0];
      end else begin
         quo   = dec_quo;
         digit = dec_rem[DIGIT_W-1:0];
      end
   end

   assign space = !rsp_valid_ff || !rsp_stall;
   assign pop   = cmd.emit && space && (count_ff != '0);

   assign sts.hex      = hex_ff;
   assign sts.quo_zero = (quo == '0);
   assign sts.last_pop = pop && (count_ff == COUNT_W'(1));

   always_comb begin
      work_in      = work_ff;
      hex_in       = hex_ff;
      count_in     = count_ff;
      stack_in     = stack_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.load) begin
         work_in  = req_value;
         hex_in   = req_hex_mode;
         count_in = '0;
      end
      if (cmd.step) begin
         work_in     = quo;
         count_in    = count_ff + COUNT_W'(1);
         stack_in[0] = digit;
         for (int i = 1; i < STACK_DEPTH; i++) begin
            stack_in[i] = stack_ff[i-1];
         end
      end
      // most significant digit sits on top of the stack
      if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = digit_glyph(stack_ff[0]);
         rsp_last_in  = (count_ff == COUNT_W'(1));
         count_in     = count_ff - COUNT_W'(1);
         for (int i = 0; i < STACK_DEPTH - 1; i++) begin
            stack_in[i] = stack_ff[i+1];
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      work_ff     <= work_in;
      hex_ff      <= hex_in;
      stack_ff    <= stack_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_last_char  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(STACK_DEPTH))
      else $error("digit stack overflow");

   a_push_pop_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.step && cmd.emit))
      else $error("push and pop in the same cycle");

   a_more_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> count_ff != '0)
      else $error("non-final character shown with empty stack");

endmodule
`default_nettype wire

// ----- sv/u2a_ctrl.sv -----
// controller: sequences load, divide steps and character emission
`default_nettype none
module u2a_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output u2a_pkg::u2a_cmd_type       cmd,
   input  wire u2a_pkg::u2a_sts_type  sts
);
   import u2a_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_STEP,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;
   logic      accept;

   assign accept = req_valid && !stall_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      stall_in = stall_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               stall_in = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // hex needs no product, go straight to the digit step
            cmd.mul  = !sts.hex;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (sts.quo_zero) begin
               state_in = ST_EMIT;
            end else if (sts.hex) begin
               state_in = ST_STEP;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.last_pop) begin
               stall_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;

endmodule
`default_nettype wire

// ----- sv/unsigned_to_ascii_digits.sv -----
// Converts a 32-bit unsigned value to ASCII decimal or lower-case hex digits,
// most significant first, without leading zeros (zero gives one '0'); the
// final character of each request carries rsp_last_char. One request is
// handled at a time. Digits are found least significant first and stacked:
// a decimal digit takes a registered multiply by the reciprocal of ten,
// then remainder and push; a hex digit needs only the push. Each character
// then leaves at one per cycle through the output register, unless the
// result side stalls.
`default_nettype none
module unsigned_to_ascii_digits (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [u2a_pkg::VALUE_W-1:0]  req_value,
   input  wire logic                         req_hex_mode,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [u2a_pkg::CHAR_W-1:0]        rsp_ascii_char,
   output logic                              rsp_last_char
);
   import u2a_pkg::*;

   u2a_cmd_type cmd;
   u2a_sts_type sts;

   u2a_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   u2a_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_value      (req_value),
      .req_hex_mode   (req_hex_mode),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_char  (rsp_last_char)
   );

endmodule
`default_nettype wire
